/* rtl/wjps_pkg.sv */
package wjps_pkg;

   localparam int WEIGHT_W = 16;
   localparam int UNITS_W = 16;
   localparam int PRODUCT_W = WEIGHT_W + UNITS_W;
   localparam int COST_W = 48;
   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 72;

   localparam logic ACT_ARRIVE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP,
      OP_DEC
   } cell_op_type;

   typedef struct packed {
      logic valid;
      logic [WEIGHT_W-1:0] weight;
      logic [UNITS_W-1:0] units;
   } slot_type;

   typedef struct packed {
      cell_op_type op;
      logic [WEIGHT_W-1:0] weight;
      logic [UNITS_W-1:0] units;
   } cell_cmd_type;

endpackage

/* rtl/weighted_job_priority_scheduler_top.sv */
// Preemptive weighted job scheduler built as a sorted chain of cells, the highest-weight
// and newest job always at the head. An item passes through ST_IDLE, which accepts it and
// registers the weight times units product, and ST_EXEC, which updates the chain (insert
// with a one-step shift, decrement of the head, removal of the head with a one-step shift,
// or a drop of an arrival when full) together with the 48-bit saturating cost total, and
// loads the result register. The next item is accepted in the cycle after that, so no item
// is taken before the last is through; a result that waits holds ST_EXEC.
module weighted_job_priority_scheduler_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: job_weight[15:0], job_units[31:16].
   input  logic [wjps_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: action[0].
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0: served[0], served_weight[16:1], job_done[17], dropped[18],
   // pending_cost[66:19], zero fill[71:67].
   output logic [wjps_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import wjps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic act_ff, act_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [UNITS_W-1:0] units_ff, units_in;
   logic [PRODUCT_W-1:0] product_ff, product_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   slot_type slots [QUEUE_DEPTH];
   logic ahead [QUEUE_DEPTH];
   cell_op_type chain_op;
   cell_op_type head_op;

   logic go;
   logic full;
   logic head_valid;
   logic served;
   logic done;
   logic dropped;
   logic [WEIGHT_W-1:0] served_weight;
   logic [COST_W:0] cost_sum;
   logic [COST_W-1:0] cost_add;
   logic [COST_W-1:0] cost_sub;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign full = slots[QUEUE_DEPTH-1].valid;
   assign head_valid = slots[0].valid;
   assign go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign cost_sum = {1'b0, cost_ff} + {{(COST_W + 1 - PRODUCT_W){1'b0}}, product_ff};
   assign cost_add = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
   assign cost_sub = (cost_ff >= {{(COST_W - WEIGHT_W){1'b0}}, slots[0].weight}) ?
                     (cost_ff - {{(COST_W - WEIGHT_W){1'b0}}, slots[0].weight}) :
                     {COST_W{1'b0}};

   always_comb begin
      chain_op = OP_HOLD;
      head_op = OP_HOLD;
      served = 1'b0;
      done = 1'b0;
      dropped = 1'b0;
      served_weight = '0;
      cost_in = cost_ff;
      if (go) begin
         unique case (act_ff)
            ACT_ARRIVE: begin
               if (units_ff != '0) begin
                  if (full) begin
                     dropped = 1'b1;
                  end else begin
                     chain_op = OP_INSERT;
                     head_op = OP_INSERT;
                     cost_in = cost_add;
                  end
               end
            end
            ACT_TICK: begin
               if (head_valid) begin
                  served = 1'b1;
                  served_weight = slots[0].weight;
                  cost_in = cost_sub;
                  if (slots[0].units == UNITS_W'(1)) begin
                     done = 1'b1;
                     chain_op = OP_POP;
                     head_op = OP_POP;
                  end else begin
                     head_op = OP_DEC;
                  end
               end
            end
            default: begin
               cost_in = cost_ff;
            end
         endcase
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_cmd_type cmd;
      slot_type left_slot;
      slot_type right_slot;
      logic left_ahead;

      assign cmd.op = (i == 0) ? head_op : chain_op;
      assign cmd.weight = weight_ff;
      assign cmd.units = units_ff;

      if (i == 0) begin : g_first
         assign left_slot = '0;
         assign left_ahead = 1'b1;
      end else begin : g_inner
         assign left_slot = slots[i-1];
         assign left_ahead = ahead[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_slot = '0;
      end else begin : g_body
         assign right_slot = slots[i+1];
      end

      wjps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_slot  (left_slot),
         .left_ahead (left_ahead),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .ahead      (ahead[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      weight_in = weight_ff;
      units_in = units_ff;
      product_in = product_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in = req_tuser[0];
               weight_in = req_tdata[WEIGHT_W-1:0];
               units_in = req_tdata[WEIGHT_W +: UNITS_W];
               product_in = req_tdata[WEIGHT_W-1:0] * req_tdata[WEIGHT_W +: UNITS_W];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {{(RSP_DATA_W - COST_W - WEIGHT_W - 3){1'b0}},
                              cost_in, dropped, done, served_weight, served};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cost_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cost_ff <= cost_in;
      end
      act_ff <= act_in;
      weight_ff <= weight_in;
      units_ff <= units_in;
      product_ff <= product_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   for (genvar k = 1; k < QUEUE_DEPTH; k++) begin : g_chk
      a_sorted_packed: assert property (@(posedge clock) disable iff (reset)
         slots[k].valid |-> (slots[k-1].valid && (slots[k-1].weight >= slots[k].weight)))
         else $error("Cell chain lost its packing or weight order.");
   end

   a_served_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[0] && rsp_data_ff[WEIGHT_W + 2]))
      else $error("Result reports both a served unit and a dropped job.");

   a_done_served: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[0]) |->
         (!rsp_data_ff[WEIGHT_W + 1] && (rsp_data_ff[WEIGHT_W:1] == '0)))
      else $error("Result without a served unit carries a weight or a finished job.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(cost_ff)))
      else $error("Cost total moved while a result was still waiting.");
`endif

endmodule

/* rtl/wjps_cell.sv */
module wjps_cell (
   input  logic clock,
   input  logic reset,
   input  wjps_pkg::cell_cmd_type cmd,
   input  wjps_pkg::slot_type left_slot,
   input  logic left_ahead,
   input  wjps_pkg::slot_type right_slot,
   output wjps_pkg::slot_type slot,
   output logic ahead
);
   import wjps_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   // The chain is sorted by falling weight, and among equal weights the newest job
   // comes first, so a new job goes in front of every job whose weight is not larger.
   assign ahead = slot_ff.valid && (slot_ff.weight > cmd.weight);
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      unique case (cmd.op)
         OP_HOLD: begin
            slot_in = slot_ff;
         end
         OP_INSERT: begin
            if (ahead) begin
               slot_in = slot_ff;
            end else if (left_ahead) begin
               slot_in.valid = 1'b1;
               slot_in.weight = cmd.weight;
               slot_in.units = cmd.units;
            end else begin
               slot_in = left_slot;
            end
         end
         OP_POP: begin
            slot_in = right_slot;
         end
         OP_DEC: begin
            slot_in.units = slot_ff.units - UNITS_W'(1);
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule
